>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker in hsv_checker.sv
// every macro samples on clk and is disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every sampled edge
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hsv_pkg.sv
package hsv_pkg;

  // full scale of saturation, value and the rgb channels
  localparam logic [8:0] FULL_SCALE = 9'd256;

  // 1.0 in the q0.24 domain of s*f
  localparam logic [25:0] ONE24 = 26'd16777216;

  // cycles from an accepted request to its done strobe
  localparam int unsigned LATENCY = 5;

  // hue sector, integer part of hue * 6
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  // front stage output: clamped inputs split into sector and fraction
  typedef struct packed {
    logic        valid;
    sector_t     sector;
    logic [15:0] frac;
    logic [8:0]  sat;
    logic [8:0]  val;
  } hsv_entry_t;

  // the four channel terms ready for routing
  typedef struct packed {
    logic       valid;
    sector_t    sector;
    logic [8:0] ta;
    logic [8:0] tb;
    logic [8:0] tc;
    logic [8:0] td;
  } hsv_terms_t;

  // saturate a 9-bit level to full scale
  function automatic logic [8:0] clamp_level(input logic [8:0] x);
    return (x > FULL_SCALE) ? FULL_SCALE : x;
  endfunction

endpackage

>>> hw/rtl/hsv_sector.sv
module hsv_sector (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        hue,
  input  logic [8:0]         saturation,
  input  logic [8:0]         brightness_value,
  output hsv_pkg::hsv_entry_t entry
);

  logic [18:0] h6;

  // hue * 6 as shift and add
  assign h6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= start;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    entry.sector <= hsv_pkg::sector_t'(h6[18:16]);
    entry.frac   <= h6[15:0];
    entry.sat    <= hsv_pkg::clamp_level(saturation);
    entry.val    <= hsv_pkg::clamp_level(brightness_value);
  end

endmodule

>>> hw/rtl/hsv_terms.sv
module hsv_terms (
  input  logic                clk,
  input  logic                rst,
  input  hsv_pkg::hsv_entry_t entry,
  output hsv_pkg::hsv_terms_t terms
);

  // stage a: s * f
  logic              a_valid;
  hsv_pkg::sector_t  a_sector;
  logic [8:0]        a_sat;
  logic [8:0]        a_val;
  logic [8:0]        a_qb;
  logic [24:0]       a_sf;

  // stage b: scale factors of the c and d terms
  logic              b_valid;
  hsv_pkg::sector_t  b_sector;
  logic [8:0]        b_val;
  logic [8:0]        b_qb;
  logic [24:0]       b_qc;
  logic [24:0]       b_qd;

  logic [25:0] qc_next;
  logic [25:0] qd_next;
  logic [17:0] pb;
  logic [33:0] pc;
  logic [33:0] pd;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      terms.valid <= 1'b0;
    end else begin
      a_valid     <= entry.valid;
      b_valid     <= a_valid;
      terms.valid <= b_valid;
    end
  end

  // stage a: saturation times fraction
  always_ff @(posedge clk) begin
    a_sector <= entry.sector;
    a_sat    <= entry.sat;
    a_val    <= entry.val;
    a_qb     <= hsv_pkg::FULL_SCALE - entry.sat;
    a_sf     <= 25'(entry.sat) * 25'(entry.frac);
  end

  // 1 - s*f and 1 - s*(1-f), both within 0..2^24
  assign qc_next = hsv_pkg::ONE24 - {1'b0, a_sf};
  assign qd_next = hsv_pkg::ONE24 - {1'b0, a_sat, 16'd0} + {1'b0, a_sf};

  always_ff @(posedge clk) begin
    b_sector <= a_sector;
    b_val    <= a_val;
    b_qb     <= a_qb;
    b_qc     <= qc_next[24:0];
    b_qd     <= qd_next[24:0];
  end

  // value products, truncated by dropping the fraction bits
  assign pb = 18'(b_val) * 18'(b_qb);
  assign pc = 34'(b_val) * 34'(b_qc);
  assign pd = 34'(b_val) * 34'(b_qd);

  always_ff @(posedge clk) begin
    terms.sector <= b_sector;
    terms.ta     <= b_val;
    terms.tb     <= pb[16:8];
    terms.tc     <= pc[32:24];
    terms.td     <= pd[32:24];
  end

endmodule

>>> hw/rtl/hsv_select.sv
module hsv_select (
  input  logic                clk,
  input  logic                rst,
  input  hsv_pkg::hsv_terms_t terms,
  output logic                done,
  output logic [8:0]          red,
  output logic [8:0]          green,
  output logic [8:0]          blue
);

  logic [8:0] red_next;
  logic [8:0] green_next;
  logic [8:0] blue_next;

  // route terms to channels by sector
  always_comb begin
    case (terms.sector)
      hsv_pkg::SEC_RED: begin
        red_next = terms.ta; green_next = terms.td; blue_next = terms.tb;
      end
      hsv_pkg::SEC_YELLOW: begin
        red_next = terms.tc; green_next = terms.ta; blue_next = terms.tb;
      end
      hsv_pkg::SEC_GREEN: begin
        red_next = terms.tb; green_next = terms.ta; blue_next = terms.td;
      end
      hsv_pkg::SEC_CYAN: begin
        red_next = terms.tb; green_next = terms.tc; blue_next = terms.ta;
      end
      hsv_pkg::SEC_BLUE: begin
        red_next = terms.td; green_next = terms.tb; blue_next = terms.ta;
      end
      hsv_pkg::SEC_MAGENTA: begin
        red_next = terms.ta; green_next = terms.tb; blue_next = terms.tc;
      end
      default: begin
        red_next = terms.ta; green_next = terms.tb; blue_next = terms.tc;
      end
    endcase
  end

  // output strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= terms.valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

endmodule

>>> hw/rtl/hsv_to_rgb_convert_unit.sv
// channel   direction  signals
// request   in         start, busy | hue, saturation, brightness_value
// result    out        done        | red, green, blue
//
// five register stages: clamp and sector split, s*f, scale factors,
// value products, channel routing into the output register
// one request per cycle; done follows start through the valid bit of every register stage
// busy stays low: the pipeline never stops, so nothing stalls
// rst is synchronous and clears only the valid bits

module hsv_to_rgb_convert_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] hue,
  input  logic [8:0]  saturation,
  input  logic [8:0]  brightness_value,
  output logic        done,
  output logic [8:0]  red,
  output logic [8:0]  green,
  output logic [8:0]  blue
);

  hsv_pkg::hsv_entry_t entry;
  hsv_pkg::hsv_terms_t terms;

  // the pipeline takes a request every cycle
  assign busy = 1'b0;

  // clamp and split hue into sector and fraction
  hsv_sector u_sector (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .hue              (hue),
    .saturation       (saturation),
    .brightness_value (brightness_value),
    .entry            (entry)
  );

  // channel terms
  hsv_terms u_terms (
    .clk   (clk),
    .rst   (rst),
    .entry (entry),
    .terms (terms)
  );

  // route to red, green and blue
  hsv_select u_select (
    .clk   (clk),
    .rst   (rst),
    .terms (terms),
    .done  (done),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

endmodule

>>> hw/rtl/hsv_checker.sv
`include "assert_macros.svh"

module hsv_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [8:0]  saturation,
  input logic        done,
  input logic [8:0]  red,
  input logic [8:0]  green,
  input logic [8:0]  blue
);

  logic [hsv_pkg::LATENCY-1:0] seen;
  logic                        levels_ok;

  // requests in flight as seen at the ports
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else begin
      seen <= {seen[hsv_pkg::LATENCY-2:0], start & ~busy};
    end
  end

  // every channel within full scale
  assign levels_ok = (red <= hsv_pkg::FULL_SCALE) && (green <= hsv_pkg::FULL_SCALE) &&
                     (blue <= hsv_pkg::FULL_SCALE);

  `ASSERT_ALWAYS(never_busy, !busy, "busy raised")
  `ASSERT_ALWAYS(done_tracks_req, done == seen[hsv_pkg::LATENCY-1], "done out of step")
  `ASSERT_IMPLIES(rgb_in_range, done, levels_ok, "channel above full scale")
  `ASSERT_IMPLIES(grey_equal, done && ($past(saturation, hsv_pkg::LATENCY) == 9'd0), (red == green) && (green == blue), "grey request not grey")

endmodule

bind hsv_to_rgb_convert_unit hsv_checker u_hsv_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .saturation (saturation),
  .done       (done),
  .red        (red),
  .green      (green),
  .blue       (blue)
);

>>> test/hsv_to_rgb_checker.sv
module hsv_to_rgb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] hue,
  input  logic [8:0]  saturation,
  input  logic [8:0]  brightness_value,
  input  logic        done,
  input  logic [8:0]  red,
  input  logic [8:0]  green,
  input  logic [8:0]  blue,
  output int          mismatches,
  output int          outstanding,
  output int          compared
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
  } rgb_t;

  rgb_t rgb_expected[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    compared    = 0;
  end

  // levels above full scale are treated as full scale
  function automatic logic [63:0] level_limit(input logic [8:0] x);
    logic [63:0] wide;
    wide = {55'd0, x};
    return (wide > 64'd256) ? 64'd256 : wide;
  endfunction

  // hsv to rgb with truncated products, sector picked from hue * 6
  function automatic rgb_t predict_rgb(input logic [15:0] h, input logic [8:0] s_in,
                                       input logic [8:0] v_in);
    logic [63:0]      s;
    logic [63:0]      v;
    logic [18:0]      h6;
    logic [63:0]      f;
    logic [63:0]      ta;
    logic [63:0]      tb;
    logic [63:0]      tc;
    logic [63:0]      td;
    hsv_pkg::sector_t sec;
    rgb_t             res;
    s = level_limit(s_in);
    v = level_limit(v_in);
    if (s == 64'd0) begin
      res.r = v[8:0];
      res.g = v[8:0];
      res.b = v[8:0];
      return res;
    end
    h6  = {3'd0, h} * 19'd6;
    sec = hsv_pkg::sector_t'(h6[18:16]);
    f   = {48'd0, h6[15:0]};
    ta  = v;
    tb  = (v * (64'd256 - s)) >> 8;
    tc  = (v * ((64'd1 << 24) - s * f)) >> 24;
    td  = (v * ((64'd1 << 24) - s * (64'd65536 - f))) >> 24;
    case (sec)
      hsv_pkg::SEC_RED:     res = '{ta[8:0], td[8:0], tb[8:0]};
      hsv_pkg::SEC_YELLOW:  res = '{tc[8:0], ta[8:0], tb[8:0]};
      hsv_pkg::SEC_GREEN:   res = '{tb[8:0], ta[8:0], td[8:0]};
      hsv_pkg::SEC_CYAN:    res = '{tb[8:0], tc[8:0], ta[8:0]};
      hsv_pkg::SEC_BLUE:    res = '{td[8:0], tb[8:0], ta[8:0]};
      default:              res = '{ta[8:0], tb[8:0], tc[8:0]};
    endcase
    return res;
  endfunction

  // compare each result with the oldest prediction, then log new requests
  always @(posedge clk) begin
    rgb_t want;
    if (!rst) begin
      if (done !== 1'b0) begin
        if (rgb_expected.size() == 0) begin
          $display("%0t: result with no request pending (done=%b rgb=%0d,%0d,%0d)",
                   $time, done, red, green, blue);
          mismatches = mismatches + 1;
        end else begin
          want = rgb_expected.pop_front();
          compared = compared + 1;
          if (done !== 1'b1) begin
            $display("%0t: done expected 1, got %b", $time, done);
            mismatches = mismatches + 1;
          end
          if (red !== want.r) begin
            $display("%0t: red expected %0d, got %0d", $time, want.r, red);
            mismatches = mismatches + 1;
          end
          if (green !== want.g) begin
            $display("%0t: green expected %0d, got %0d", $time, want.g, green);
            mismatches = mismatches + 1;
          end
          if (blue !== want.b) begin
            $display("%0t: blue expected %0d, got %0d", $time, want.b, blue);
            mismatches = mismatches + 1;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        rgb_expected.push_back(predict_rgb(hue, saturation, brightness_value));
    end
    outstanding = rgb_expected.size();
  end

endmodule

>>> test/tb_hsv_to_rgb_convert_unit.sv
module tb_hsv_to_rgb_convert_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_REQUESTS = 400;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [15:0] hue = '0;
  logic [8:0]  saturation = '0;
  logic [8:0]  brightness_value = '0;
  logic        busy;
  logic        done;
  logic [8:0]  red;
  logic [8:0]  green;
  logic [8:0]  blue;

  int mismatches;
  int outstanding;
  int compared;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned grey_sent = 0;
  int unsigned over_range_sent = 0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hsv_to_rgb_convert_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .hue              (hue),
    .saturation       (saturation),
    .brightness_value (brightness_value),
    .done             (done),
    .red              (red),
    .green            (green),
    .blue             (blue)
  );

  hsv_to_rgb_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .hue              (hue),
    .saturation       (saturation),
    .brightness_value (brightness_value),
    .done             (done),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .compared         (compared)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("hsv_to_rgb_convert_unit verification failed");
      $finish;
    end
  end

  // present one request; returns at the edge that accepts it
  task automatic send_color(input logic [15:0] h, input logic [8:0] s, input logic [8:0] v);
    start            <= 1'b1;
    hue              <= h;
    saturation       <= s;
    brightness_value <= v;
    @(negedge clk);
    while (busy !== 1'b0) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    sent = sent + 1;
    if (s == 9'd0)
      grey_sent = grey_sent + 1;
    if (s > hsv_pkg::FULL_SCALE || v > hsv_pkg::FULL_SCALE)
      over_range_sent = over_range_sent + 1;
  endtask

  // idle between requests: mostly none, sometimes short, rarely long
  task automatic idle_gap(input int unsigned n);
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (n % 64 < 16 || pick < 55)
      len = 0;
    else if (pick < 90)
      len = $urandom_range(1, 3);
    else
      len = $urandom_range(8, 40);
    if (len != 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // random request mix: grey, over-range, full, sector edges, general
  task automatic send_random(input int unsigned n);
    logic [15:0] h;
    logic [8:0]  s;
    logic [8:0]  v;
    int unsigned kind;
    int unsigned k;
    kind = $urandom_range(0, 9);
    h = 16'($urandom);
    s = 9'($urandom_range(1, 256));
    v = 9'($urandom_range(0, 256));
    case (kind)
      0: begin
        s = 9'd0;
        v = 9'($urandom_range(0, 511));
      end
      1: begin
        s = 9'($urandom_range(0, 511));
        v = 9'($urandom_range(257, 511));
      end
      2: s = 9'($urandom_range(257, 511));
      3: begin
        s = hsv_pkg::FULL_SCALE;
        v = hsv_pkg::FULL_SCALE;
      end
      4, 5: begin
        k = $urandom_range(1, 5);
        h = 16'((k * 65536 + 5) / 6 + $urandom_range(0, 4) - 2);
      end
      default: ;
    endcase
    send_color(h, s, v);
    idle_gap(n);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // grey, hue extremes and level extremes
    send_color(16'h0000, 9'd0,   9'd0);
    send_color(16'h0000, 9'd0,   9'd256);
    send_color(16'hFFFF, 9'd0,   9'd511);
    send_color(16'h0000, 9'd256, 9'd256);
    send_color(16'hFFFF, 9'd256, 9'd256);
    send_color(16'hFFFF, 9'd511, 9'd511);
    // both sides of every sector boundary
    send_color(16'd10922, 9'd256, 9'd256);
    send_color(16'd10923, 9'd256, 9'd256);
    send_color(16'd21845, 9'd256, 9'd200);
    send_color(16'd21846, 9'd256, 9'd200);
    send_color(16'd32767, 9'd256, 9'd256);
    send_color(16'd32768, 9'd256, 9'd256);
    send_color(16'd43690, 9'd128, 9'd256);
    send_color(16'd43691, 9'd128, 9'd256);
    send_color(16'd54613, 9'd256, 9'd256);
    send_color(16'd54614, 9'd256, 9'd256);
    // saturation and value above full scale, tiny levels, alternating bits
    send_color(16'd12345, 9'd257, 9'd300);
    send_color(16'd40000, 9'd1,   9'd1);
    send_color(16'd20000, 9'd255, 9'd255);
    send_color(16'd8000,  9'd256, 9'd0);
    send_color(16'd50000, 9'd300, 9'd0);
    send_color(16'h5555,  9'h1AA, 9'h155);
    send_color(16'hAAAA,  9'h155, 9'h0AA);
    start <= 1'b0;
    repeat (3) @(posedge clk);

    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++)
      send_random(n);
    start <= 1'b0;

    // drain, then allow for any stray strobes
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (hsv_pkg::LATENCY + 8) @(posedge clk);

    $display("summary: %0d colors sent (%0d grey, %0d with levels above full scale),",
             sent, grey_sent, over_range_sent);
    $display("  %0d results compared, %0d mismatches", compared, mismatches);
    if (mismatches == 0)
      $display("hsv_to_rgb_convert_unit verification clean");
    else
      $display("hsv_to_rgb_convert_unit verification failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/hsv_pkg.sv
hw/rtl/hsv_sector.sv
hw/rtl/hsv_terms.sv
hw/rtl/hsv_select.sv
hw/rtl/hsv_to_rgb_convert_unit.sv
hw/rtl/hsv_checker.sv
test/hsv_to_rgb_checker.sv
test/tb_hsv_to_rgb_convert_unit.sv
